// ===== src/owbm_pkg.sv =====
// Package with the shared types and constants of the one-wire bus master.
`default_nettype none
package owbm_pkg;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_WRITE    = 3'd4,
		PH_READ     = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_RESET_LOW  = 3'd0,
		REG_PRES_SAMP  = 3'd1,
		REG_RESET_TAIL = 3'd2,
		REG_SLOT       = 3'd3,
		REG_WR1_LOW    = 3'd4,
		REG_RD_LOW     = 3'd5,
		REG_RD_SAMPLE  = 3'd6
	} reg_idx_t;

	localparam int unsigned CFG_W = 10;
	localparam int unsigned CNT_W = 10;

	localparam logic [9:0] RESET_LOW_INIT  = 10'd500;
	localparam logic [9:0] PRES_SAMP_INIT  = 10'd50;
	localparam logic [9:0] RESET_TAIL_INIT = 10'd430;
	localparam logic [7:0] SLOT_INIT       = 8'd60;
	localparam logic [7:0] WR1_LOW_INIT    = 8'd1;
	localparam logic [7:0] RD_LOW_INIT     = 8'd2;
	localparam logic [7:0] RD_SAMPLE_INIT  = 8'd12;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [9:0] presence_sample_us;
		logic [9:0] reset_tail_us;
		logic [7:0] slot_us;
		logic [7:0] write_one_low_us;
		logic [7:0] read_low_us;
		logic [7:0] read_sample_us;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] micro_count;
		logic [2:0]       bit_index;
		logic [7:0]       shift_byte;
		logic             presence_flag;
		logic [7:0]       last_read;
	} state_t;

	typedef struct packed {
		logic       rejected;
		logic       presence;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} result_t;

endpackage
`default_nettype wire

// ===== src/owbm_step.sv =====
// Next-state and result logic for one request of the one-wire bus master.
`default_nettype none
module owbm_step (
	input  owbm_pkg::cfg_t    cfg,
	input  owbm_pkg::state_t  cur,
	input  owbm_pkg::opcode_t opcode,
	input  logic [7:0]        data_byte,
	input  logic              line_level,
	output owbm_pkg::state_t  nxt,
	output owbm_pkg::result_t res
);

	logic [owbm_pkg::CNT_W-1:0] cnt_inc;
	logic [7:0]                 slot_len;
	logic [7:0]                 samp_raw;
	logic [7:0]                 samp;
	logic                       slot_end;
	logic                       last_bit;
	logic [7:0]                 low_time;
	logic                       rej;
	logic                       done;

	assign cnt_inc  = cur.micro_count + 10'd1;
	assign slot_len = (cfg.slot_us == 8'd0) ? 8'd1 : cfg.slot_us;
	assign samp_raw = (cfg.read_sample_us == 8'd0) ? 8'd1 : cfg.read_sample_us;
	assign samp     = (samp_raw > slot_len) ? slot_len : samp_raw;
	assign slot_end = cnt_inc >= {2'b00, slot_len};
	assign last_bit = cur.bit_index == 3'd7;

	always_comb begin
		nxt  = cur;
		rej  = 1'b0;
		done = 1'b0;
		if (opcode != owbm_pkg::OP_TICK) begin
			if (cur.phase != owbm_pkg::PH_IDLE) begin
				// A running sequence goes on untouched.
				rej = 1'b1;
			end else begin
				nxt.micro_count = '0;
				nxt.bit_index   = 3'd0;
				unique case (opcode)
					owbm_pkg::OP_RESET: begin
						nxt.phase         = owbm_pkg::PH_RST_LOW;
						nxt.presence_flag = 1'b0;
					end
					owbm_pkg::OP_WRITE: begin
						nxt.phase      = owbm_pkg::PH_WRITE;
						nxt.shift_byte = data_byte;
					end
					default: begin
						nxt.phase      = owbm_pkg::PH_READ;
						nxt.shift_byte = 8'd0;
					end
				endcase
			end
		end else begin
			unique case (cur.phase)
				owbm_pkg::PH_IDLE: ;
				owbm_pkg::PH_RST_LOW: begin
					nxt.micro_count = cnt_inc;
					if (cnt_inc >= cfg.reset_low_us) begin
						nxt.phase       = owbm_pkg::PH_RST_WAIT;
						nxt.micro_count = '0;
					end
				end
				owbm_pkg::PH_RST_WAIT: begin
					nxt.micro_count = cnt_inc;
					if (cnt_inc >= cfg.presence_sample_us) begin
						nxt.presence_flag = ~line_level;
						nxt.micro_count   = '0;
						if (cfg.reset_tail_us == 10'd0) begin
							nxt.phase = owbm_pkg::PH_IDLE;
							done      = 1'b1;
						end else begin
							nxt.phase = owbm_pkg::PH_RST_TAIL;
						end
					end
				end
				owbm_pkg::PH_RST_TAIL: begin
					nxt.micro_count = cnt_inc;
					if (cnt_inc >= cfg.reset_tail_us) begin
						nxt.phase       = owbm_pkg::PH_IDLE;
						nxt.micro_count = '0;
						done            = 1'b1;
					end
				end
				owbm_pkg::PH_WRITE: begin
					nxt.micro_count = cnt_inc;
					if (slot_end) begin
						nxt.shift_byte  = {1'b0, cur.shift_byte[7:1]};
						nxt.micro_count = '0;
						if (last_bit) begin
							nxt.phase     = owbm_pkg::PH_IDLE;
							nxt.bit_index = 3'd0;
							done          = 1'b1;
						end else begin
							nxt.bit_index = cur.bit_index + 3'd1;
						end
					end
				end
				owbm_pkg::PH_READ: begin
					nxt.micro_count = cnt_inc;
					if (cnt_inc == {2'b00, samp}) begin
						nxt.shift_byte = {line_level, cur.shift_byte[7:1]};
					end
					if (slot_end) begin
						nxt.micro_count = '0;
						if (last_bit) begin
							nxt.phase     = owbm_pkg::PH_IDLE;
							nxt.bit_index = 3'd0;
							nxt.last_read = nxt.shift_byte;
							done          = 1'b1;
						end else begin
							nxt.bit_index = cur.bit_index + 3'd1;
						end
					end
				end
				default: begin
					nxt.phase       = owbm_pkg::PH_IDLE;
					nxt.micro_count = '0;
				end
			endcase
		end
	end

	// Low time of the slot now running, taken from the updated state.
	always_comb begin
		case (nxt.phase)
			owbm_pkg::PH_WRITE: low_time = nxt.shift_byte[0] ? cfg.write_one_low_us : slot_len;
			owbm_pkg::PH_READ:  low_time = cfg.read_low_us;
			default:            low_time = 8'd0;
		endcase
	end

	always_comb begin
		res.drive_low = (nxt.phase == owbm_pkg::PH_RST_LOW) ||
			(((nxt.phase == owbm_pkg::PH_WRITE) || (nxt.phase == owbm_pkg::PH_READ)) &&
			(nxt.micro_count < {2'b00, low_time}));
		res.busy_res  = nxt.phase != owbm_pkg::PH_IDLE;
		res.done_res  = done;
		res.read_data = nxt.last_read;
		res.presence  = nxt.presence_flag;
		res.rejected  = rej;
	end

endmodule
`default_nettype wire

// ===== src/one_wire_bus_master.sv =====
// Top level of the one-wire bus master: configuration, state and result register.
`default_nettype none
// One-wire bus master timed in microsecond ticks. Each request on the slave
// stream is either a tick (tuser zero), which carries the sampled bus level and
// advances the slot timing, or a command: a reset with presence detect, an
// LSB-first byte write, or an LSB-first byte read. Every request gives exactly
// one result on the master stream with the open-drain drive for the next
// microsecond, the busy and done flags, the last byte read, the presence flag
// and a flag for a command that was dropped because a sequence was running.
// A request is taken whenever the result register is free: all its work is a
// counter step and a few compares between the state registers and the result
// register, so the rate is one request per clock while the sink keeps up, and
// the result shows in the cycle after acceptance. The result register is the
// only stage; a new request is taken while it is empty or while its contents
// are being taken in the same cycle. Timing registers are written through the
// cfg port and should be changed only while the bus master is idle.
module one_wire_bus_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                               // [10:3] read_data, [11] presence, [12] rejected
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [owbm_pkg::CFG_W-1:0] cfg_wdata
);

	owbm_pkg::cfg_t    cfg_q;
	owbm_pkg::state_t  state_q;
	owbm_pkg::state_t  state_nxt;
	owbm_pkg::result_t res;
	owbm_pkg::result_t res_q;
	logic              out_valid_q;
	logic              accept;

	assign s_tready = ~out_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	// Register writes; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us       <= owbm_pkg::RESET_LOW_INIT;
			cfg_q.presence_sample_us <= owbm_pkg::PRES_SAMP_INIT;
			cfg_q.reset_tail_us      <= owbm_pkg::RESET_TAIL_INIT;
			cfg_q.slot_us            <= owbm_pkg::SLOT_INIT;
			cfg_q.write_one_low_us   <= owbm_pkg::WR1_LOW_INIT;
			cfg_q.read_low_us        <= owbm_pkg::RD_LOW_INIT;
			cfg_q.read_sample_us     <= owbm_pkg::RD_SAMPLE_INIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				owbm_pkg::REG_RESET_LOW:  cfg_q.reset_low_us       <= cfg_wdata;
				owbm_pkg::REG_PRES_SAMP:  cfg_q.presence_sample_us <= cfg_wdata;
				owbm_pkg::REG_RESET_TAIL: cfg_q.reset_tail_us      <= cfg_wdata;
				owbm_pkg::REG_SLOT:       cfg_q.slot_us            <= cfg_wdata[7:0];
				owbm_pkg::REG_WR1_LOW:    cfg_q.write_one_low_us   <= cfg_wdata[7:0];
				owbm_pkg::REG_RD_LOW:     cfg_q.read_low_us        <= cfg_wdata[7:0];
				owbm_pkg::REG_RD_SAMPLE:  cfg_q.read_sample_us     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	owbm_step u_step (
		.cfg        (cfg_q),
		.cur        (state_q),
		.opcode     (owbm_pkg::opcode_t'(s_tuser)),
		.data_byte  (s_tdata[7:0]),
		.line_level (s_tdata[8]),
		.nxt        (state_nxt),
		.res        (res)
	);

	// Sequence state moves only when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= owbm_pkg::PH_IDLE;
			state_q.micro_count   <= '0;
			state_q.bit_index     <= 3'd0;
			state_q.shift_byte    <= 8'd0;
			state_q.presence_flag <= 1'b0;
			state_q.last_read     <= 8'd0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q};

endmodule
`default_nettype wire

// ===== src/owbm_checker.sv =====
// Port-level checker for the one-wire bus master and its bind.
`default_nettype none
module owbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A result waiting for the sink keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// Every taken request shows a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("request taken without a result");

	// The finishing tick releases the line and leaves the master idle.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (!m_tdata[1] && !m_tdata[0]))
		else $error("done while busy or driving");

	// The line is never pulled low by an idle master.
	a_idle_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> !m_tdata[0])
		else $error("line driven while idle");

	// A dropped command can only happen while a sequence runs.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[12]) |-> (m_tdata[1] && !m_tdata[2]))
		else $error("command dropped while idle");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== sim/tb_one_wire_bus_master.sv =====
// Self-checking testbench for the one-wire bus master: stream driver, result monitor and predictor.
`timescale 1ns / 1ps

module tb_one_wire_bus_master;

	// The run ends here even if requests or results stall forever.
	localparam int CYCLE_LIMIT = 10000000;
	// Index past the last timing register; a write to it must change nothing.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// One request as the driver puts it on the slave stream.
	typedef struct packed {
		owbm_pkg::opcode_t op;
		logic [7:0]        data;
		logic              level;
	} bus_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [owbm_pkg::CFG_W-1:0] cfg_wdata = '0;

	one_wire_bus_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Requests waiting to be driven, and the bus results still owed by the block.
	bus_req_t          pending_req[$];
	owbm_pkg::result_t owed_results[$];
	int n_requests = 0;
	int n_results = 0;
	int n_errors = 0;
	int cycles = 0;

	// Idle behavior of each side: 0 never idles, 1 idles for a gap from draw_gap after
	// every request, 2 idles only now and then.
	int send_mode = 0;
	int recv_mode = 0;

	// Our own copy of the timing registers, kept in step with every cfg write.
	owbm_pkg::cfg_t tcfg = '{
		reset_low_us:       owbm_pkg::RESET_LOW_INIT,
		presence_sample_us: owbm_pkg::PRES_SAMP_INIT,
		reset_tail_us:      owbm_pkg::RESET_TAIL_INIT,
		slot_us:            owbm_pkg::SLOT_INIT,
		write_one_low_us:   owbm_pkg::WR1_LOW_INIT,
		read_low_us:        owbm_pkg::RD_LOW_INIT,
		read_sample_us:     owbm_pkg::RD_SAMPLE_INIT
	};

	// Bus master state as the predictor tracks it.
	owbm_pkg::phase_t bus_phase = owbm_pkg::PH_IDLE;
	logic [9:0] slot_tick = '0;
	logic [2:0] bit_pos = '0;
	logic [7:0] shift_reg = '0;
	logic       presence_seen = 1'b0;
	logic [7:0] last_byte = '0;

	// Advances the bus master by one request and returns the result it must give.
	function automatic owbm_pkg::result_t bus_step(input owbm_pkg::opcode_t op,
			input logic [7:0] data, input logic level);
		owbm_pkg::result_t res;
		logic [7:0] slot_len;
		logic [7:0] sample_at;
		logic [7:0] low_len;
		res = '0;
		slot_len = (tcfg.slot_us == 8'd0) ? 8'd1 : tcfg.slot_us;
		sample_at = (tcfg.read_sample_us == 8'd0) ? 8'd1 : tcfg.read_sample_us;
		// A sample point past the slot end falls on the last tick of the slot.
		if (sample_at > slot_len)
			sample_at = slot_len;

		if (op != owbm_pkg::OP_TICK) begin
			// Commands are only taken while idle; otherwise they are dropped.
			if (bus_phase != owbm_pkg::PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				slot_tick = '0;
				bit_pos = '0;
				case (op)
					owbm_pkg::OP_RESET: begin
						bus_phase = owbm_pkg::PH_RST_LOW;
						presence_seen = 1'b0;
					end
					owbm_pkg::OP_WRITE: begin
						bus_phase = owbm_pkg::PH_WRITE;
						shift_reg = data;
					end
					default: begin
						bus_phase = owbm_pkg::PH_READ;
						shift_reg = '0;
					end
				endcase
			end
		end else begin
			slot_tick = slot_tick + 10'd1;
			case (bus_phase)
				owbm_pkg::PH_RST_LOW: begin
					if (slot_tick >= tcfg.reset_low_us) begin
						bus_phase = owbm_pkg::PH_RST_WAIT;
						slot_tick = '0;
					end
				end
				owbm_pkg::PH_RST_WAIT: begin
					if (slot_tick >= tcfg.presence_sample_us) begin
						// A slave answers by holding the line low.
						presence_seen = ~level;
						slot_tick = '0;
						if (tcfg.reset_tail_us == 10'd0) begin
							bus_phase = owbm_pkg::PH_IDLE;
							res.done_res = 1'b1;
						end else begin
							bus_phase = owbm_pkg::PH_RST_TAIL;
						end
					end
				end
				owbm_pkg::PH_RST_TAIL: begin
					if (slot_tick >= tcfg.reset_tail_us) begin
						bus_phase = owbm_pkg::PH_IDLE;
						slot_tick = '0;
						res.done_res = 1'b1;
					end
				end
				owbm_pkg::PH_WRITE, owbm_pkg::PH_READ: begin
					// Reads sample even while the line is still driven low.
					if (bus_phase == owbm_pkg::PH_READ && slot_tick == {2'b00, sample_at})
						shift_reg = {level, shift_reg[7:1]};
					if (slot_tick >= {2'b00, slot_len}) begin
						if (bus_phase == owbm_pkg::PH_WRITE)
							shift_reg = shift_reg >> 1;
						slot_tick = '0;
						if (bit_pos == 3'd7) begin
							if (bus_phase == owbm_pkg::PH_READ)
								last_byte = shift_reg;
							bus_phase = owbm_pkg::PH_IDLE;
							bit_pos = '0;
							res.done_res = 1'b1;
						end else begin
							bit_pos = bit_pos + 3'd1;
						end
					end
				end
				default: begin
					// A tick while idle does nothing.
					bus_phase = owbm_pkg::PH_IDLE;
					slot_tick = '0;
				end
			endcase
		end

		// Line drive for the coming microsecond. A zero bit holds the line low for
		// the whole slot; a one bit and a read only for their low time.
		case (bus_phase)
			owbm_pkg::PH_RST_LOW: begin
				res.drive_low = 1'b1;
			end
			owbm_pkg::PH_WRITE: begin
				low_len = shift_reg[0] ? tcfg.write_one_low_us : slot_len;
				res.drive_low = slot_tick < {2'b00, low_len};
			end
			owbm_pkg::PH_READ: begin
				res.drive_low = slot_tick < {2'b00, tcfg.read_low_us};
			end
			default: ;
		endcase
		res.busy_res = bus_phase != owbm_pkg::PH_IDLE;
		res.read_data = last_byte;
		res.presence = presence_seen;
		return res;
	endfunction

	function automatic int draw_gap(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 19);
			default: return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19) : 0;
		endcase
	endfunction

	// Driver: feeds the slave stream from pending_req and predicts each accepted
	// request at the edge that takes it.
	always @(posedge clk or negedge arst_n) begin : driver
		static int gap = 0;
		bus_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				owed_results.push_back(bus_step(owbm_pkg::opcode_t'(s_tuser),
					s_tdata[7:0], s_tdata[8]));
			if (!s_tvalid || s_tready) begin
				if (gap != 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_req.size() != 0) begin
					nxt = pending_req.pop_front();
					s_tuser <= nxt.op;
					s_tdata <= {7'd0, nxt.level, nxt.data};
					s_tvalid <= 1'b1;
					gap = draw_gap(send_mode);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			n_errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Monitor: takes results with random stalls and checks each against the
	// oldest owed result.
	always @(posedge clk or negedge arst_n) begin : monitor
		static int stall = 0;
		owbm_pkg::result_t got;
		owbm_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[12:0];
				n_results++;
				if (owed_results.size() == 0) begin
					n_errors++;
					$display("%0t ns: result expected none, got %h", $time, m_tdata);
				end else begin
					want = owed_results.pop_front();
					check_field("drive_low", want.drive_low, got.drive_low);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("read_data", want.read_data, got.read_data);
					check_field("presence", want.presence, got.presence);
					check_field("rejected", want.rejected, got.rejected);
				end
				stall = draw_gap(recv_mode);
			end
			if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_req(input owbm_pkg::opcode_t op, input logic [7:0] data,
			input logic level);
		pending_req.push_back('{op: op, data: data, level: level});
		n_requests++;
	endtask

	// Writes one register; cfg_we stays high for back-to-back writes and is
	// dropped by close_writes.
	task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			owbm_pkg::REG_RESET_LOW:  tcfg.reset_low_us = val;
			owbm_pkg::REG_PRES_SAMP:  tcfg.presence_sample_us = val;
			owbm_pkg::REG_RESET_TAIL: tcfg.reset_tail_us = val;
			owbm_pkg::REG_SLOT:       tcfg.slot_us = val[7:0];
			owbm_pkg::REG_WR1_LOW:    tcfg.write_one_low_us = val[7:0];
			owbm_pkg::REG_RD_LOW:     tcfg.read_low_us = val[7:0];
			owbm_pkg::REG_RD_SAMPLE:  tcfg.read_sample_us = val[7:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Ticks a command needs to run to completion under the current timing.
	function automatic int ticks_needed(input owbm_pkg::opcode_t op);
		int low_len;
		int wait_len;
		int slot_len;
		low_len = (tcfg.reset_low_us == 10'd0) ? 1 : int'(tcfg.reset_low_us);
		wait_len = (tcfg.presence_sample_us == 10'd0) ? 1 : int'(tcfg.presence_sample_us);
		slot_len = (tcfg.slot_us == 8'd0) ? 1 : int'(tcfg.slot_us);
		if (op == owbm_pkg::OP_RESET)
			return low_len + wait_len + int'(tcfg.reset_tail_us);
		return 8 * slot_len;
	endfunction

	// Mostly whole command sequences with random data and bus levels. Some are
	// cut short so the next command lands on a busy master, and now and then a
	// stray command is slipped between ticks.
	task automatic run_traffic(input int target);
		int made;
		int n;
		owbm_pkg::opcode_t op;
		made = 0;
		while (made < target) begin
			op = owbm_pkg::opcode_t'($urandom_range(1, 3));
			push_req(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(0, ticks_needed(op));
			else
				n = ticks_needed(op) + $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 29) == 0)
					push_req(owbm_pkg::opcode_t'($urandom_range(1, 3)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				push_req(owbm_pkg::OP_TICK, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
			made += n + 1;
		end
	endtask

	// Waits until every result is in, then ticks the master back to idle so
	// the timing registers may be changed.
	task automatic settle();
		while (n_results < n_requests)
			@(posedge clk);
		while (bus_phase != owbm_pkg::PH_IDLE) begin
			for (int i = 0; i < 32; i++)
				push_req(owbm_pkg::OP_TICK, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			while (n_results < n_requests)
				@(posedge clk);
		end
	endtask

	// Timing values are mostly small so sequences stay short, with a few large.
	function automatic logic [9:0] pick_timing();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 10'($urandom_range(0, 8));
		if (r < 96)
			return 10'($urandom_range(0, 40));
		return 10'($urandom_range(0, 1023));
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// One sequence at the reset timing values, with no idling.
		run_traffic(1);
		settle();

		// Directed part: a tick while idle, a reset that sees presence with no
		// tail, a command dropped while busy, a write of all ones with no low
		// phase for a one, and a read whose sample point lies past the slot end
		// and inside the low phase.
		send_mode = 2;
		recv_mode = 2;
		write_reg(owbm_pkg::REG_RESET_LOW, 10'd2);
		write_reg(owbm_pkg::REG_PRES_SAMP, 10'd1);
		write_reg(owbm_pkg::REG_RESET_TAIL, 10'd0);
		write_reg(owbm_pkg::REG_SLOT, 10'd1);
		write_reg(owbm_pkg::REG_WR1_LOW, 10'd0);
		write_reg(owbm_pkg::REG_RD_LOW, 10'd3);
		write_reg(owbm_pkg::REG_RD_SAMPLE, 10'd5);
		close_writes();
		push_req(owbm_pkg::OP_TICK, 8'hFF, 1'b1);
		push_req(owbm_pkg::OP_RESET, 8'h00, 1'b1);
		push_req(owbm_pkg::OP_READ, 8'h00, 1'b1);
		for (int i = 0; i < 3; i++)
			push_req(owbm_pkg::OP_TICK, 8'h00, 1'b0);
		push_req(owbm_pkg::OP_WRITE, 8'hFF, 1'b0);
		for (int i = 0; i < 8; i++)
			push_req(owbm_pkg::OP_TICK, 8'h00, 1'b0);
		push_req(owbm_pkg::OP_READ, 8'h00, 1'b0);
		for (int i = 0; i < 8; i++)
			push_req(owbm_pkg::OP_TICK, 8'hFF, 1'b1);
		settle();

		// All registers at their largest value; the 8-bit ones see the upper
		// write bits dropped.
		send_mode = 0;
		recv_mode = $urandom_range(0, 2);
		for (int i = owbm_pkg::REG_RESET_LOW; i <= owbm_pkg::REG_RD_SAMPLE; i++)
			write_reg(3'(i), 10'h3FF);
		close_writes();
		run_traffic(1);
		settle();

		// All zero: every zero length acts as one or skips its phase. A write to
		// the unused index must leave the timing alone.
		send_mode = 1;
		recv_mode = 1;
		for (int i = owbm_pkg::REG_RESET_LOW; i <= owbm_pkg::REG_RD_SAMPLE; i++)
			write_reg(3'(i), 10'd0);
		write_reg(REG_UNUSED, 10'h3FF);
		close_writes();
		run_traffic(120);
		settle();

		// Lowest legal values.
		send_mode = 2;
		recv_mode = 0;
		write_reg(owbm_pkg::REG_RESET_LOW, 10'd1);
		write_reg(owbm_pkg::REG_PRES_SAMP, 10'd1);
		write_reg(owbm_pkg::REG_RESET_TAIL, 10'd0);
		write_reg(owbm_pkg::REG_SLOT, 10'd2);
		write_reg(owbm_pkg::REG_WR1_LOW, 10'd1);
		write_reg(owbm_pkg::REG_RD_LOW, 10'd1);
		write_reg(owbm_pkg::REG_RD_SAMPLE, 10'd1);
		close_writes();
		run_traffic(120);
		settle();

		// Random timing sets, each with its own idle pattern on both sides.
		for (int ph = 0; ph < 10; ph++) begin
			send_mode = $urandom_range(0, 2);
			recv_mode = $urandom_range(0, 2);
			for (int i = owbm_pkg::REG_RESET_LOW; i <= owbm_pkg::REG_RD_SAMPLE; i++)
				if ($urandom_range(0, 2) != 0)
					write_reg(3'(i), pick_timing());
			close_writes();
			run_traffic(100);
			settle();
		end

		// Give a stray late result time to show up.
		repeat (20) @(posedge clk);
		if (owed_results.size() != 0) begin
			n_errors++;
			$display("%0t ns: %0d results expected, got none", $time, owed_results.size());
		end
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
